FILE: sv/gmc_pkg.sv
`default_nettype none

package gmc_pkg;

  // spread and level width
  localparam int SPREAD_W = 16;
  localparam int LVL_W    = 16;

  // sample counters saturate here
  localparam int CTR_W = 10;
  localparam logic [CTR_W-1:0] CTR_MAX = 10'd1023;

  // config port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_TRANS = 3'd0,
    REG_START_WALK  = 3'd1,
    REG_STAIRS_UP   = 3'd2,
    REG_STAIRS_DOWN = 3'd3,
    REG_WALK_DOWN   = 3'd4,
    REG_TRANS_DOWN  = 3'd5,
    REG_COOLDOWN    = 3'd6,
    REG_INTERVAL    = 3'd7
  } cfg_idx_t;

  // config reset values
  localparam logic [LVL_W-1:0] RST_START_TRANS = 16'd768;
  localparam logic [LVL_W-1:0] RST_START_WALK  = 16'd1024;
  localparam logic [LVL_W-1:0] RST_STAIRS_UP   = 16'd1280;
  localparam logic [LVL_W-1:0] RST_STAIRS_DOWN = 16'd1331;
  localparam logic [LVL_W-1:0] RST_WALK_DOWN   = 16'd717;
  localparam logic [LVL_W-1:0] RST_TRANS_DOWN  = 16'd410;
  localparam logic [CTR_W-1:0] RST_COOLDOWN    = 10'd200;
  localparam logic [CTR_W-1:0] RST_INTERVAL    = 10'd50;

  // motion state codes as seen on the output
  typedef enum logic [1:0] {
    MS_IDLE       = 2'd0,
    MS_TRANSITION = 2'd1,
    MS_WALKING    = 2'd2,
    MS_STAIRS     = 2'd3
  } motion_t;

  // scan result from the ring to the top level
  typedef struct packed {
    logic                done;
    logic [SPREAD_W-1:0] spread;
  } scan_stat_t;

endpackage

`default_nettype wire

FILE: sv/gait_mode_classifier_core.sv
// Flow: an item without analysis goes from acceptance through the DONE state
// into the output register; an analysing item first waits in the SCAN state
// for the ring scan, which reads one memory entry per cycle.
// The core takes no new item until the current result has left the DONE state;
// a result stalled on out_tready holds off the next input beat.
// Reset clears all control state and config registers; the ring memory is not
// cleared, only entries already written are ever scanned.
`default_nettype none

module gait_mode_classifier_core #(
  parameter int DEPTH       = 200,
  parameter int MIN_SAMPLES = 50,
  parameter int POS_WIDTH   = 16,
  localparam int IN_TDATA_W = ((2 * POS_WIDTH + 7) / 8) * 8
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  // position_a, position_b, zero pad
  input  wire logic [IN_TDATA_W-1:0]           in_tdata,
  // classify_enable
  input  wire logic                            in_tuser,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  // motion_state[1:0], state_changed[2], spread[18:3], zero pad
  output logic [23:0]                          out_tdata,
  // analysed
  output logic                                 out_tuser,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [gmc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [gmc_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int SLOT_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam bit MIN_OK = (MIN_SAMPLES <= DEPTH);
  localparam logic [CNT_W-1:0] MIN_CNT  = MIN_OK ? CNT_W'(MIN_SAMPLES) : '0;
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(DEPTH - 1);
  localparam int CTR_W = gmc_pkg::CTR_W;
  localparam int LVL_W = gmc_pkg::LVL_W;
  localparam int CHG_BIT = 2;

  typedef enum logic [2:0] {
    CTL_IDLE = 3'b001,
    CTL_SCAN = 3'b010,
    CTL_DONE = 3'b100
  } ctl_t;

  ctl_t ctl_r;

  logic [LVL_W-1:0] start_trans_r, start_walk_r, stairs_up_r;
  logic [LVL_W-1:0] stairs_down_r, walk_down_r, trans_down_r;
  logic [CTR_W-1:0] cooldown_r, interval_r;

  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CTR_W-1:0]  ss_r, ss_nxt;
  logic [CTR_W-1:0]  sa_r, sa_nxt;
  gmc_pkg::motion_t  cur_r, ns;

  logic in_accept, due, high, hold, enough, analyze, out_free, do_switch;

  gmc_pkg::motion_t             pend_state_r;
  logic                         pend_chg_r, pend_an_r;
  logic [gmc_pkg::SPREAD_W-1:0] pend_spread_r;

  logic                         out_tvalid_r;
  gmc_pkg::motion_t             out_state_r;
  logic                         out_chg_r, out_an_r;
  logic [gmc_pkg::SPREAD_W-1:0] out_spread_r;

  logic signed [POS_WIDTH-1:0]  pos_a, pos_b;
  gmc_pkg::scan_stat_t          ring_stat;

  assign pos_a = in_tdata[POS_WIDTH-1:0];
  assign pos_b = in_tdata[2*POS_WIDTH-1:POS_WIDTH];

  // config register file
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_trans_r <= gmc_pkg::RST_START_TRANS;
      start_walk_r  <= gmc_pkg::RST_START_WALK;
      stairs_up_r   <= gmc_pkg::RST_STAIRS_UP;
      stairs_down_r <= gmc_pkg::RST_STAIRS_DOWN;
      walk_down_r   <= gmc_pkg::RST_WALK_DOWN;
      trans_down_r  <= gmc_pkg::RST_TRANS_DOWN;
      cooldown_r    <= gmc_pkg::RST_COOLDOWN;
      interval_r    <= gmc_pkg::RST_INTERVAL;
    end else if (cfg_valid) begin
      case (gmc_pkg::cfg_idx_t'(cfg_index))
        gmc_pkg::REG_START_TRANS: start_trans_r <= cfg_data;
        gmc_pkg::REG_START_WALK:  start_walk_r  <= cfg_data;
        gmc_pkg::REG_STAIRS_UP:   stairs_up_r   <= cfg_data;
        gmc_pkg::REG_STAIRS_DOWN: stairs_down_r <= cfg_data;
        gmc_pkg::REG_WALK_DOWN:   walk_down_r   <= cfg_data;
        gmc_pkg::REG_TRANS_DOWN:  trans_down_r  <= cfg_data;
        gmc_pkg::REG_COOLDOWN:    cooldown_r    <= cfg_data[CTR_W-1:0];
        gmc_pkg::REG_INTERVAL:    interval_r    <= cfg_data[CTR_W-1:0];
        default: ;
      endcase
    end
  end

  // per-sample bookkeeping and analysis decision
  assign in_tready = (ctl_r == CTL_IDLE);
  assign in_accept = in_tvalid && in_tready;

  assign slot_nxt = (slot_r == LAST_SLOT) ? '0 : slot_r + SLOT_W'(1);
  assign cnt_nxt  = (cnt_r == FULL_CNT) ? cnt_r : cnt_r + CNT_W'(1);
  assign ss_nxt   = (ss_r == gmc_pkg::CTR_MAX) ? ss_r : ss_r + CTR_W'(1);
  assign sa_nxt   = (sa_r == gmc_pkg::CTR_MAX) ? sa_r : sa_r + CTR_W'(1);

  assign due     = (sa_nxt >= interval_r);
  assign high    = (cur_r == gmc_pkg::MS_WALKING) || (cur_r == gmc_pkg::MS_STAIRS);
  assign hold    = high && (ss_nxt < cooldown_r);
  assign enough  = MIN_OK && (cnt_nxt >= MIN_CNT);
  assign analyze = due && in_tuser && !hold && enough;

  // hysteresis step on the scanned spread
  always_comb begin
    ns = cur_r;
    case (cur_r)
      gmc_pkg::MS_IDLE: begin
        if (ring_stat.spread > start_walk_r) ns = gmc_pkg::MS_WALKING;
        else if (ring_stat.spread > start_trans_r) ns = gmc_pkg::MS_TRANSITION;
      end
      gmc_pkg::MS_TRANSITION: begin
        if (ring_stat.spread > start_walk_r) ns = gmc_pkg::MS_WALKING;
        else if (ring_stat.spread < trans_down_r) ns = gmc_pkg::MS_IDLE;
      end
      gmc_pkg::MS_WALKING: begin
        if (ring_stat.spread > stairs_up_r) ns = gmc_pkg::MS_STAIRS;
        else if (ring_stat.spread < walk_down_r) ns = gmc_pkg::MS_TRANSITION;
      end
      default: begin
        if (ring_stat.spread < stairs_down_r) ns = gmc_pkg::MS_WALKING;
      end
    endcase
  end

  // walking <-> stairs restarts the cooldown
  assign do_switch = high && (ns != cur_r) &&
                     ((ns == gmc_pkg::MS_WALKING) || (ns == gmc_pkg::MS_STAIRS));

  assign out_free = !out_tvalid_r || out_tready;

  // control sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r        <= CTL_IDLE;
      slot_r       <= '0;
      cnt_r        <= '0;
      cur_r        <= gmc_pkg::MS_IDLE;
      ss_r         <= gmc_pkg::CTR_MAX;
      sa_r         <= gmc_pkg::CTR_MAX;
      out_tvalid_r <= 1'b0;
    end else begin
      case (ctl_r)
        CTL_IDLE: begin
          if (in_accept) begin
            slot_r <= slot_nxt;
            cnt_r  <= cnt_nxt;
            ss_r   <= ss_nxt;
            sa_r   <= due ? '0 : sa_nxt;
            ctl_r  <= analyze ? CTL_SCAN : CTL_DONE;
          end
        end
        CTL_SCAN: begin
          if (ring_stat.done) begin
            cur_r <= ns;
            if (do_switch) ss_r <= '0;
            ctl_r <= CTL_DONE;
          end
        end
        CTL_DONE: begin
          if (out_free) ctl_r <= CTL_IDLE;
        end
        default: ctl_r <= CTL_IDLE;
      endcase

      if (ctl_r == CTL_DONE && out_free) out_tvalid_r <= 1'b1;
      else if (out_tready) out_tvalid_r <= 1'b0;
    end
  end

  // pending result and output register
  always_ff @(posedge clk) begin
    if (ctl_r == CTL_IDLE && in_accept) begin
      pend_state_r  <= cur_r;
      pend_chg_r    <= 1'b0;
      pend_an_r     <= 1'b0;
      pend_spread_r <= '0;
    end else if (ctl_r == CTL_SCAN && ring_stat.done) begin
      pend_state_r  <= ns;
      pend_chg_r    <= (ns != cur_r);
      pend_an_r     <= 1'b1;
      pend_spread_r <= ring_stat.spread;
    end
    if (ctl_r == CTL_DONE && out_free) begin
      out_state_r  <= pend_state_r;
      out_chg_r    <= pend_chg_r;
      out_an_r     <= pend_an_r;
      out_spread_r <= pend_spread_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tuser  = out_an_r;
  assign out_tdata  = {5'd0, out_spread_r, out_chg_r, out_state_r};

  gmc_ring #(
    .DEPTH     (DEPTH),
    .POS_WIDTH (POS_WIDTH)
  ) u_ring (
    .clk        (clk),
    .rst_n      (rst_n),
    .wr_en      (in_accept),
    .wr_addr    (slot_r),
    .wr_data    ({pos_b, pos_a}),
    .scan_start (in_accept && analyze),
    .scan_len   (cnt_nxt),
    .stat       (ring_stat)
  );

  // a scan result only arrives while the sequencer waits for it
  a_done_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    ring_stat.done |-> (ctl_r == CTL_SCAN))
    else $error("scan done outside scan wait");

  // motion state moves only at the end of a scan
  a_state_only_on_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl_r != CTL_SCAN) |=> $stable(cur_r))
    else $error("motion state changed without a scan");

  // an analysis point restarts the interval count
  a_interval_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && due) |=> (sa_r == '0))
    else $error("interval counter not restarted");

  // a state change can only come from an analysed beat
  a_change_needs_analysis: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[CHG_BIT]) |-> out_tuser)
    else $error("state change flagged without analysis");

endmodule

`default_nettype wire

FILE: sv/gmc_ring.sv
`default_nettype none

// Sample ring memory plus a min/max scan engine that reads one entry per cycle.
module gmc_ring #(
  parameter int DEPTH     = 200,
  parameter int POS_WIDTH = 16,
  localparam int SLOT_W   = $clog2(DEPTH),
  localparam int CNT_W    = $clog2(DEPTH + 1)
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   wr_en,
  input  wire logic [SLOT_W-1:0]      wr_addr,
  input  wire logic [2*POS_WIDTH-1:0] wr_data,
  input  wire logic                   scan_start,
  input  wire logic [CNT_W-1:0]       scan_len,
  output gmc_pkg::scan_stat_t         stat
);

  localparam int DIFF_W = POS_WIDTH + 1;

  logic [2*POS_WIDTH-1:0] mem [DEPTH];

  logic [SLOT_W-1:0]      rd_addr_r;
  logic [CNT_W-1:0]       issue_left_r;
  logic [2*POS_WIDTH-1:0] rd_data_r;
  logic                   rd_vld_r;
  logic                   rd_last_r;
  logic                   first_r;
  logic                   fin1_r;
  logic                   done_r;

  logic signed [POS_WIDTH-1:0] hi_a_r, lo_a_r, hi_b_r, lo_b_r;
  logic signed [POS_WIDTH-1:0] smp_a, smp_b;
  logic [DIFF_W-1:0]           diff_a_r, diff_b_r;
  logic [DIFF_W-1:0]           diff_max;
  logic [32:0]                 diff_ext;
  logic [gmc_pkg::SPREAD_W-1:0] spread_sat;

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr_r];
  end

  // read sequencing
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      issue_left_r <= '0;
      rd_addr_r    <= '0;
      rd_vld_r     <= 1'b0;
      rd_last_r    <= 1'b0;
      first_r      <= 1'b0;
      fin1_r       <= 1'b0;
      done_r       <= 1'b0;
    end else begin
      rd_vld_r  <= 1'b0;
      rd_last_r <= 1'b0;
      fin1_r    <= 1'b0;
      done_r    <= fin1_r;
      if (scan_start) begin
        issue_left_r <= scan_len;
        rd_addr_r    <= '0;
        first_r      <= 1'b1;
      end else if (issue_left_r != '0) begin
        issue_left_r <= issue_left_r - CNT_W'(1);
        rd_addr_r    <= rd_addr_r + SLOT_W'(1);
        rd_vld_r     <= 1'b1;
        rd_last_r    <= (issue_left_r == CNT_W'(1));
      end
      if (rd_vld_r) begin
        first_r <= 1'b0;
        fin1_r  <= rd_last_r;
      end
    end
  end

  assign smp_a = rd_data_r[POS_WIDTH-1:0];
  assign smp_b = rd_data_r[2*POS_WIDTH-1:POS_WIDTH];

  // running extremes per channel
  always_ff @(posedge clk) begin
    if (rd_vld_r) begin
      if (first_r || smp_a > hi_a_r) hi_a_r <= smp_a;
      if (first_r || smp_a < lo_a_r) lo_a_r <= smp_a;
      if (first_r || smp_b > hi_b_r) hi_b_r <= smp_b;
      if (first_r || smp_b < lo_b_r) lo_b_r <= smp_b;
    end
  end

  // max minus min once the last sample is folded in, one extra bit so it
  // stays non-negative
  always_ff @(posedge clk) begin
    if (fin1_r) begin
      diff_a_r <= DIFF_W'({hi_a_r[POS_WIDTH-1], hi_a_r} - {lo_a_r[POS_WIDTH-1], lo_a_r});
      diff_b_r <= DIFF_W'({hi_b_r[POS_WIDTH-1], hi_b_r} - {lo_b_r[POS_WIDTH-1], lo_b_r});
    end
  end

  // larger channel, saturated to the spread width
  assign diff_max   = (diff_a_r > diff_b_r) ? diff_a_r : diff_b_r;
  assign diff_ext   = 33'(diff_max);
  assign spread_sat = (diff_ext > 33'd65535) ? 16'hFFFF : diff_ext[15:0];

  assign stat.done   = done_r;
  assign stat.spread = spread_sat;

endmodule

`default_nettype wire
